>>> rtl/core/dsfr_pkg.sv
// Shared types and constants of the STX/ETX/DLE frame receiver.
// No dependencies; used by dsfr_crc_byte and dle_stuffed_frame_receiver_unit.
package dsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Line control characters
  localparam logic [ByteW-1:0] ChStx = 8'h02;
  localparam logic [ByteW-1:0] ChEtx = 8'h03;
  localparam logic [ByteW-1:0] ChDle = 8'h10;

  // Register map
  localparam logic [CfgIdxW-1:0] CfgCrcPoly = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCrcInit = 2'd1;

  localparam logic [CrcW-1:0] CrcPolyReset = 16'h1021;
  localparam logic [CrcW-1:0] CrcInitReset = 16'hFFFF;

  typedef enum logic [1:0] {
    StWait   = 2'd0,
    StFresh  = 2'd1,
    StUnmask = 2'd2,
    StSave   = 2'd3
  } parse_state_e;

  typedef enum logic [KindW-1:0] {
    KindData   = 2'd0,
    KindGood   = 2'd1,
    KindCrcErr = 2'd2,
    KindOvf    = 2'd3
  } kind_e;

endpackage

>>> rtl/core/dsfr_crc_byte.sv
// One-byte MSB-first CRC-16 update with a programmable polynomial.
// Depends on dsfr_pkg for widths.
module dsfr_crc_byte (
  input  logic [dsfr_pkg::CrcW-1:0]  poly_i,
  input  logic [dsfr_pkg::CrcW-1:0]  crc_i,
  input  logic [dsfr_pkg::ByteW-1:0] byte_i,
  output logic [dsfr_pkg::CrcW-1:0]  crc_o
);

  always_comb begin
    logic [dsfr_pkg::CrcW-1:0] c;
    c = crc_i ^ {byte_i, {(dsfr_pkg::CrcW - dsfr_pkg::ByteW){1'b0}}};
    for (int i = 0; i < dsfr_pkg::ByteW; i++) begin
      if (c[dsfr_pkg::CrcW-1]) begin
        c = {c[dsfr_pkg::CrcW-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[dsfr_pkg::CrcW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

>>> rtl/core/dle_stuffed_frame_receiver_unit.sv
// STX/ETX deframer with DLE unstuffing, frame length count and CRC-16 check.
// Depends on dsfr_pkg and dsfr_crc_byte.
//
// The receiver takes one line byte per clock while not stalled and, when the
// byte produces a result, presents it on the output stream in the cycle after
// acceptance. Input and output are parted by a single result register, so a
// new byte is taken in every cycle in which that register is empty or being
// drained; the path that sets the clock is the eight-step CRC fold of one byte.
// Each payload byte comes out with its position; ETX after payload gives a
// good or CRC-error item with the command byte and the length. Once a frame
// exceeds MAX_FRAME payload bytes, one overflow item is sent and all further
// bytes are discarded until reset. Write the CRC registers only while the
// block is idle; a new initial value applies from the next STX.
module dle_stuffed_frame_receiver_unit #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dsfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsfr_pkg::CrcW-1:0]     cfg_data_i,
  // Received line bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] source_error
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [14:8] byte_index, [15] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME);

  logic [dsfr_pkg::CrcW-1:0] poly_q, init_q;

  dsfr_pkg::parse_state_e    state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [dsfr_pkg::CrcW-1:0] crc_q, crc_d;
  logic [dsfr_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic                      ovf_q, ovf_d;

  logic                       out_valid_q;
  dsfr_pkg::kind_e            out_kind_q, emit_kind;
  logic [dsfr_pkg::ByteW-1:0] out_data_q, emit_data;
  logic [dsfr_pkg::IdxW-1:0]  out_idx_q, emit_idx;
  logic                       emit;

  logic                       accept, do_store;
  logic [dsfr_pkg::ByteW-1:0] rx_byte;
  logic [CntW-1:0]            pos;
  logic [dsfr_pkg::CrcW-1:0]  crc_base, crc_fold;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;

  // Just after STX the frame restarts, so store from cleared values
  assign pos      = (state_q == dsfr_pkg::StFresh) ? '0 : cnt_q;
  assign crc_base = (state_q == dsfr_pkg::StFresh) ? init_q : crc_q;

  dsfr_crc_byte u_crc (
    .poly_i (poly_q),
    .crc_i  (crc_base),
    .byte_i (rx_byte),
    .crc_o  (crc_fold)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= dsfr_pkg::CrcPolyReset;
      init_q <= dsfr_pkg::CrcInitReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dsfr_pkg::CfgCrcPoly: poly_q <= cfg_data_i;
        dsfr_pkg::CfgCrcInit: init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    cmd_d     = cmd_q;
    ovf_d     = ovf_q;
    emit      = 1'b0;
    emit_kind = dsfr_pkg::KindData;
    emit_data = rx_byte;
    emit_idx  = dsfr_pkg::IdxW'(pos);
    do_store  = 1'b0;

    if (accept && !ovf_q) begin
      if (s_axis_tuser) begin
        // Drop the frame
        state_d = dsfr_pkg::StWait;
        cnt_d   = '0;
        crc_d   = init_q;
        cmd_d   = '0;
      end else begin
        unique case (state_q)
          dsfr_pkg::StWait: begin
            if (rx_byte == dsfr_pkg::ChStx) state_d = dsfr_pkg::StFresh;
          end
          dsfr_pkg::StFresh: begin
            cnt_d = '0;
            crc_d = init_q;
            cmd_d = '0;
            if (rx_byte == dsfr_pkg::ChStx) begin
              state_d = dsfr_pkg::StFresh;
            end else if (rx_byte == dsfr_pkg::ChEtx) begin
              state_d = dsfr_pkg::StWait;
            end else if (rx_byte == dsfr_pkg::ChDle) begin
              state_d = dsfr_pkg::StUnmask;
            end else begin
              state_d  = dsfr_pkg::StSave;
              do_store = 1'b1;
            end
          end
          dsfr_pkg::StUnmask: begin
            state_d  = dsfr_pkg::StSave;
            do_store = 1'b1;
          end
          dsfr_pkg::StSave: begin
            if (rx_byte == dsfr_pkg::ChDle) begin
              state_d = dsfr_pkg::StUnmask;
            end else if (rx_byte == dsfr_pkg::ChStx) begin
              state_d = dsfr_pkg::StFresh;
            end else if (rx_byte == dsfr_pkg::ChEtx) begin
              state_d   = dsfr_pkg::StWait;
              emit      = 1'b1;
              emit_kind = (crc_q == '0) ? dsfr_pkg::KindGood : dsfr_pkg::KindCrcErr;
              emit_data = cmd_q;
              emit_idx  = dsfr_pkg::IdxW'(cnt_q);
            end else begin
              do_store = 1'b1;
            end
          end
          default: state_d = dsfr_pkg::StWait;
        endcase
      end
    end

    if (do_store) begin
      emit = 1'b1;
      if (pos >= CntMax) begin
        // Frame too long: report once, then go deaf until reset
        ovf_d     = 1'b1;
        emit_kind = dsfr_pkg::KindOvf;
      end else begin
        if (pos == CntW'(1)) cmd_d = rx_byte;
        cnt_d = pos + CntW'(1);
        crc_d = crc_fold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsfr_pkg::StWait;
      cnt_q   <= '0;
      crc_q   <= dsfr_pkg::CrcInitReset;
      cmd_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q <= emit_kind;
      out_data_q <= emit_data;
      out_idx_q  <= emit_idx;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {1'b0, out_idx_q, out_data_q};

  // Overflow is sticky until reset
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared without reset");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("byte count past maximum frame length");

  a_ovf_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == dsfr_pkg::KindOvf) |-> ovf_q)
    else $error("overflow item without overflow flag");

  a_no_item_after_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
    else $error("item produced after overflow");

endmodule

>>> test/dle_stuffed_frame_receiver_unit_test.sv
// Testbench for dle_stuffed_frame_receiver_unit: drives line bytes and CRC register writes,
// predicts payload, frame-status and overflow items, and checks each output item in order.
// Depends on dsfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module dle_stuffed_frame_receiver_unit_test;
  import dsfr_pkg::*;

  localparam int unsigned MaxFrame   = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 6;
  // Register indexes past the map; the block must ignore them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [6:0] idx;
  } frame_result_t;

  class deframer_scoreboard;
    logic [CrcW-1:0] poly_val;
    logic [CrcW-1:0] init_val;
    parse_state_e    pstate;
    int unsigned     count;
    logic [CrcW-1:0] crc;
    logic [7:0]      cmd;
    bit              overflowed;
    frame_result_t   awaited[$];
    int unsigned     errors;
    int unsigned     bytes_seen;
    int unsigned     reg_writes;
    int unsigned     kind_seen[4];

    function void reset_state();
      poly_val   = CrcPolyReset;
      init_val   = CrcInitReset;
      pstate     = StWait;
      overflowed = 1'b0;
      clear_frame();
    endfunction

    function void clear_frame();
      count = 0;
      crc   = init_val;
      cmd   = 8'h00;
    endfunction

    function logic [CrcW-1:0] fold(logic [CrcW-1:0] c, logic [7:0] b);
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ poly_val) : (c << 1);
      end
      return c;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CrcW-1:0] val);
      reg_writes++;
      if (idx == CfgCrcPoly) begin
        poly_val = val;
      end else if (idx == CfgCrcInit) begin
        init_val = val;
      end
    endfunction

    function void push_result(kind_e k, logic [7:0] d, int unsigned i);
      frame_result_t r;
      r.kind = k;
      r.data = d;
      r.idx  = 7'(i);
      awaited.push_back(r);
    endfunction

    function void take_payload(logic [7:0] b);
      if (count >= MaxFrame) begin
        overflowed = 1'b1;
        push_result(KindOvf, b, count);
      end else begin
        if (count == 1) cmd = b;
        push_result(KindData, b, count);
        count++;
        crc = fold(crc, b);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic err);
      bytes_seen++;
      if (overflowed) return;
      if (err) begin
        pstate = StWait;
        clear_frame();
        return;
      end
      case (pstate)
        StWait: begin
          if (b == ChStx) pstate = StFresh;
        end
        StFresh: begin
          clear_frame();
          if (b == ChEtx) begin
            pstate = StWait;
          end else if (b == ChDle) begin
            pstate = StUnmask;
          end else if (b != ChStx) begin
            pstate = StSave;
            take_payload(b);
          end
        end
        StUnmask: begin
          pstate = StSave;
          take_payload(b);
        end
        default: begin
          if (b == ChDle) begin
            pstate = StUnmask;
          end else if (b == ChStx) begin
            pstate = StFresh;
          end else if (b == ChEtx) begin
            pstate = StWait;
            push_result((crc == '0) ? KindGood : KindCrcErr, cmd, count);
          end else begin
            take_payload(b);
          end
        end
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [15:0] tdata, logic [1:0] tuser);
      frame_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item kind=%0d data=%02h idx=%0d",
                         tuser, tdata[7:0], tdata[14:8]));
        return;
      end
      want = awaited.pop_front();
      kind_seen[want.kind]++;
      if (tuser != want.kind)
        report($sformatf("kind %0d, want %0d", tuser, want.kind));
      if (tdata[7:0] != want.data)
        report($sformatf("data_byte %02h, want %02h", tdata[7:0], want.data));
      if (tdata[14:8] != want.idx)
        report($sformatf("byte_index %0d, want %0d", tdata[14:8], want.idx));
      if (tdata[15] !== 1'b0)
        report("tdata pad bit not zero");
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CrcW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;

  deframer_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned send_wait_max;
  int unsigned recv_wait_max;
  bit          hold_off_req;

  dle_stuffed_frame_receiver_unit #(
    .MAX_FRAME(MaxFrame)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("dle_stuffed_frame_receiver_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Output side: random stalls per item, plus one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = $urandom_range(0, recv_wait_max);
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // All driving tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic err);
    int unsigned gap;
    gap = $urandom_range(0, send_wait_max);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = err;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, err);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CrcW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 9))
      0: return ChStx;
      1: return ChEtx;
      2: return ChDle;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Escape control characters, and now and then a plain byte too
  task automatic send_payload(input logic [7:0] b);
    if (b == ChStx || b == ChEtx || b == ChDle || $urandom_range(0, 7) == 0)
      send_byte(ChDle, 1'b0);
    send_byte(b, 1'b0);
  endtask

  task automatic send_frame(input int unsigned len, input bit with_crc);
    logic [CrcW-1:0] crc;
    logic [7:0]      b;
    crc = sb.init_val;
    send_byte(ChStx, 1'b0);
    for (int i = 0; i < len; i++) begin
      b = rand_payload();
      crc = sb.fold(crc, b);
      send_payload(b);
    end
    if (with_crc) begin
      send_payload(crc[15:8]);
      send_payload(crc[7:0]);
    end
    send_byte(ChEtx, 1'b0);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned len;
    int unsigned k;
    target = sb.bytes_seen + n;
    while (sb.bytes_seen < target) begin
      case ($urandom_range(0, 9))
        0: begin
          k = $urandom_range(1, 4);
          repeat (k) send_byte(rand_payload(), $urandom_range(0, 3) == 0);
        end
        1: begin
          send_byte(ChStx, 1'b0);
          k = $urandom_range(0, 6);
          repeat (k) send_payload(rand_payload());
          case ($urandom_range(0, 2))
            0: send_byte(rand_payload(), 1'b1);
            1: begin
              send_byte(ChDle, 1'b0);
              send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: ; // leave the frame open; the next STX restarts it
          endcase
        end
        default: begin
          case ($urandom_range(0, 19))
            0: len = MaxFrame;
            1, 2: len = $urandom_range(13, MaxFrame - 2);
            default: len = $urandom_range(0, 12);
          endcase
          send_frame(len, (len <= MaxFrame - 2) && $urandom_range(0, 1));
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    send_wait_max = 12;
    recv_wait_max = 12;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgCrcPoly;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Bytes outside a frame, including an error, are ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChDle, 1'b0);
    send_byte(ChEtx, 1'b0);
    send_byte(ChStx, 1'b1);
    // Empty frame, then repeated STX and a one-byte frame
    send_byte(ChStx, 1'b0);
    send_byte(ChEtx, 1'b0);
    send_byte(ChStx, 1'b0);
    send_byte(ChStx, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(ChEtx, 1'b0);
    // Escaped control characters right after STX and mid-frame
    send_byte(ChStx, 1'b0);
    send_byte(ChDle, 1'b0);
    send_byte(ChStx, 1'b0);
    send_byte(ChDle, 1'b0);
    send_byte(ChEtx, 1'b0);
    send_byte(ChDle, 1'b0);
    send_byte(ChDle, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(ChEtx, 1'b0);
    // Restart mid-frame, then a source error drops the frame
    send_byte(ChStx, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(ChStx, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(ChEtx, 1'b0);
    // Frames with a matching CRC
    send_frame(2, 1'b1);
    send_frame(0, 1'b1);

    random_traffic(500);
    drain();

    write_reg(CfgCrcPoly, 16'h0000);
    write_reg(CfgCrcInit, 16'h0000);
    random_traffic(300);
    drain();

    write_reg(CfgCrcPoly, 16'hFFFF);
    write_reg(CfgCrcInit, 16'hFFFF);
    send_wait_max = 0;
    recv_wait_max = 0;
    random_traffic(150);
    send_wait_max = 12;
    recv_wait_max = 12;
    random_traffic(150);
    drain();

    write_reg(CfgCrcPoly, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(CfgCrcInit, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(CfgSpareLo, 16'($urandom_range(0, 16'hFFFF)));
    write_reg(CfgSpareHi, 16'($urandom_range(0, 16'hFFFF)));
    send_wait_max = 2;
    hold_off_req  = 1'b1;
    random_traffic(300);
    send_wait_max = 12;
    drain();

    write_reg(CfgCrcPoly, CrcPolyReset);
    write_reg(CfgCrcInit, 16'($urandom_range(0, 16'hFFFF)));
    random_traffic(300);
    drain();

    // Overflow last: the block discards everything after it until reset
    send_byte(ChStx, 1'b0);
    repeat (MaxFrame + 1) send_payload(rand_payload());
    send_byte(ChEtx, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(ChStx, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(ChEtx, 1'b0);
    drain();

    $display("Covered %0d line bytes and %0d register writes over five CRC settings",
             sb.bytes_seen, sb.reg_writes);
    $display("Checked %0d payload, %0d good, %0d CRC-error and %0d overflow items",
             sb.kind_seen[KindData], sb.kind_seen[KindGood], sb.kind_seen[KindCrcErr],
             sb.kind_seen[KindOvf]);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected items never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("dle_stuffed_frame_receiver_unit test passed");
    end else begin
      $display("dle_stuffed_frame_receiver_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/dsfr_pkg.sv
rtl/core/dsfr_crc_byte.sv
rtl/core/dle_stuffed_frame_receiver_unit.sv
test/dle_stuffed_frame_receiver_unit_test.sv
